// File: rtl/core/pnc_pkg.sv
package pnc_pkg;

    // Store geometry
    localparam int PAL_DEPTH = 256;
    localparam int IDX_W     = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int CNT_W     = $clog2(PAL_DEPTH + 1);
    localparam int SZ_W      = 9;
    localparam int SPAN_W    = (CNT_W > SZ_W) ? CNT_W : SZ_W;
    localparam int DIST_W    = 18;
    localparam int SQ_W      = 16;

    localparam logic [SZ_W-1:0] SIZE_RESET = SZ_W'(256);
    localparam int RESERVED_BIT = 0;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_ANIMATE = 2'd1,
        REQ_READ    = 2'd2,
        REQ_SEARCH  = 2'd3
    } req_code_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_SKIP  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_SCAN,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } entry_t;

    // Palette memory command
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_cmd_t;

    // Squared channel differences
    typedef struct packed {
        logic [SQ_W-1:0] r;
        logic [SQ_W-1:0] g;
        logic [SQ_W-1:0] b;
    } sq_t;

    typedef struct packed {
        status_t           status;
        entry_t            ent;
        logic [7:0]        near_idx;
        logic [DIST_W-1:0] near_dist;
    } result_t;

endpackage

// File: rtl/core/pnc_if.sv
// Request channel
interface pnc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_flags;

    modport source (
        output valid, req_type, entry_index, red, green, blue, entry_flags,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, red, green, blue, entry_flags,
        output ready
    );
endinterface

// Response channel
interface pnc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  read_red;
    logic [7:0]  read_green;
    logic [7:0]  read_blue;
    logic [7:0]  read_flags;
    logic [7:0]  nearest_index;
    logic [17:0] nearest_distance;

    modport source (
        output valid, status, read_red, read_green, read_blue, read_flags,
               nearest_index, nearest_distance,
        input  ready
    );
    modport sink (
        input  valid, status, read_red, read_green, read_blue, read_flags,
               nearest_index, nearest_distance,
        output ready
    );
endinterface

// File: rtl/core/palette_store_nearest_color_unit.sv
// Channel  Dir  Word
// req      in   req_type, entry_index, red, green, blue, entry_flags
// rsp      out  status, read_red/green/blue/flags, nearest_index, nearest_distance
// cfg      in   cfg_we / cfg_wdata: palette_size_in_use
//
// Write, refused index or empty search go straight to the output state; read and animate pass the access state first.
// Search walks the entries in use and stops early on an exact match;
// the single read port of the palette memory sets one entry per cycle.
// Reset clears the written flags of all entries at once; no sweep needed.
// One request in flight; ready returns once the word enters the result register.
// A finished word waits in the hold register while the result register is full.
module palette_store_nearest_color_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [pnc_pkg::SZ_W-1:0]  cfg_wdata,
    pnc_req_if.sink                   req,
    pnc_rsp_if.source                 rsp
);
    import pnc_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [SZ_W-1:0]   size_reg;
    req_code_t         op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    entry_t            col_reg, col_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0]  p1_idx_reg, p1_idx_next;
    logic              p2_valid_reg, p2_valid_next;
    logic [IDX_W-1:0]  p2_idx_reg, p2_idx_next;
    entry_t            p2_ent_reg, p2_ent_next;
    logic              best_valid_reg, best_valid_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    entry_t            best_ent_reg, best_ent_next;
    result_t           hold_reg, hold_next;
    result_t           res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    mem_cmd_t          mem_cmd;
    entry_t            rd_data;
    sq_t               sq;
    logic [DIST_W-1:0] dist_sum;
    logic [SPAN_W-1:0] n_span;
    logic [CNT_W-1:0]  n_used;
    logic [SPAN_W-1:0] in_idx_span;

    // Palette memory and distance unit
    pnc_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    pnc_dist u_dist (
        .clk (clk),
        .ent (rd_data),
        .tgt (col_reg),
        .sq  (sq)
    );

    // Entries in use, clipped to the store depth
    always_comb
    begin
        n_span      = (SPAN_W'(size_reg) > SPAN_W'(PAL_DEPTH)) ?
                      SPAN_W'(PAL_DEPTH) : SPAN_W'(size_reg);
        n_used      = CNT_W'(n_span);
        in_idx_span = SPAN_W'(req.entry_index);
        dist_sum    = DIST_W'(sq.r) + DIST_W'(sq.g) + DIST_W'(sq.b);
    end

    assign req.ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        col_next        = col_reg;
        scan_next       = scan_reg;
        p1_valid_next   = 1'b0;
        p1_idx_next     = p1_idx_reg;
        p2_valid_next   = p1_valid_reg;
        p2_idx_next     = p1_idx_reg;
        p2_ent_next     = rd_data;
        best_valid_next = best_valid_reg;
        best_dist_next  = best_dist_reg;
        best_idx_next   = best_idx_reg;
        best_ent_next   = best_ent_reg;
        hold_next       = hold_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !rsp.ready;
        mem_cmd         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req_code_t'(req.req_type);
                    idx_next  = IDX_W'(req.entry_index);
                    col_next  = '{flags: req.entry_flags, blue: req.blue,
                                  green: req.green, red: req.red};
                    hold_next = '0;
                    if (req_code_t'(req.req_type) == REQ_SEARCH)
                    begin
                        if (n_used == '0)
                        begin
                            hold_next.status = ST_RANGE;
                            state_next       = S_OUT;
                        end
                        else
                        begin
                            scan_next       = '0;
                            best_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end
                    else if (in_idx_span >= n_span)
                    begin
                        hold_next.status = ST_RANGE;
                        state_next       = S_OUT;
                    end
                    else if (req_code_t'(req.req_type) == REQ_WRITE)
                    begin
                        mem_cmd.we    = 1'b1;
                        mem_cmd.waddr = IDX_W'(req.entry_index);
                        mem_cmd.wdata = col_next;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        mem_cmd.re    = 1'b1;
                        mem_cmd.raddr = IDX_W'(req.entry_index);
                        state_next    = S_ACCESS;
                    end
                end
            end

            S_ACCESS:
            begin
                // Stored entry is on rd_data now
                if (op_reg == REQ_READ)
                begin
                    hold_next.ent = rd_data;
                end
                else if (rd_data.flags[RESERVED_BIT])
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = idx_reg;
                    mem_cmd.wdata = col_reg;
                end
                else
                begin
                    hold_next.status = ST_SKIP;
                end
                state_next = S_OUT;
            end

            S_SCAN:
            begin
                // Issue one read per cycle
                if (scan_reg < n_used)
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = IDX_W'(scan_reg);
                    p1_valid_next = 1'b1;
                    p1_idx_next   = IDX_W'(scan_reg);
                    scan_next     = scan_reg + CNT_W'(1);
                end
                // Strictly smaller wins, so the first entry is kept on ties
                if (p2_valid_reg && (!best_valid_reg || dist_sum < best_dist_reg))
                begin
                    best_valid_next = 1'b1;
                    best_dist_next  = dist_sum;
                    best_idx_next   = p2_idx_reg;
                    best_ent_next   = p2_ent_reg;
                end
                // Exact match or all entries compared
                if ((best_valid_reg && best_dist_reg == '0) ||
                    (scan_reg == n_used && !p1_valid_reg && !p2_valid_reg))
                begin
                    hold_next     = '{status: ST_DONE, ent: best_ent_reg,
                                      near_idx: 8'(best_idx_reg),
                                      near_dist: best_dist_reg};
                    p1_valid_next = 1'b0;
                    p2_valid_next = 1'b0;
                    state_next    = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!res_valid_reg || rsp.ready)
                begin
                    res_next       = hold_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            size_reg       <= SIZE_RESET;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            p1_valid_reg   <= p1_valid_next;
            p2_valid_reg   <= p2_valid_next;
            best_valid_reg <= best_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        col_reg       <= col_next;
        scan_reg      <= scan_next;
        p1_idx_reg    <= p1_idx_next;
        p2_idx_reg    <= p2_idx_next;
        p2_ent_reg    <= p2_ent_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        best_ent_reg  <= best_ent_next;
        hold_reg      <= hold_next;
        res_reg       <= res_next;
    end

    // Response word
    assign rsp.valid            = res_valid_reg;
    assign rsp.status           = 2'(res_reg.status);
    assign rsp.read_red         = res_reg.ent.red;
    assign rsp.read_green       = res_reg.ent.green;
    assign rsp.read_blue        = res_reg.ent.blue;
    assign rsp.read_flags       = res_reg.ent.flags;
    assign rsp.nearest_index    = res_reg.near_idx;
    assign rsp.nearest_distance = res_reg.near_dist;

    // Best distance only falls within one search
    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && $past(state_reg == S_SCAN) &&
         best_valid_reg && $past(best_valid_reg))
        |-> best_dist_reg <= $past(best_dist_reg))
        else $error("best distance grew during a search");

    // Scan pointer stays within the entries in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> scan_reg <= n_used)
        else $error("scan pointer beyond size in use");

    // No palette write while searching
    a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !mem_cmd.we)
        else $error("palette written during search");

    // An accepted word starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg != S_IDLE)
        else $error("accepted word dropped");

    // Compare stage is fed only from the read stage
    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> $past(p1_valid_reg))
        else $error("compare stage valid without read stage");

endmodule

// File: rtl/core/pnc_mem.sv
module pnc_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  pnc_pkg::mem_cmd_t cmd,
    output pnc_pkg::entry_t   rd_data
);
    import pnc_pkg::*;

    entry_t               store_mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] vld_reg;
    entry_t               rd_data_reg;
    logic                 rd_vld_reg;

    // Storage array, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            store_mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rd_data_reg <= store_mem[cmd.raddr];
        end
    end

    // Per-entry written flags; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.we)
            begin
                vld_reg[cmd.waddr] <= 1'b1;
            end
            if (cmd.re)
            begin
                rd_vld_reg <= vld_reg[cmd.raddr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: rtl/core/pnc_dist.sv
module pnc_dist (
    input  logic            clk,
    input  pnc_pkg::entry_t ent,
    input  pnc_pkg::entry_t tgt,
    output pnc_pkg::sq_t    sq
);
    import pnc_pkg::*;

    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    sq_t        sq_reg;

    // Absolute channel differences
    always_comb
    begin
        dr = (ent.red   > tgt.red)   ? ent.red   - tgt.red   : tgt.red   - ent.red;
        dg = (ent.green > tgt.green) ? ent.green - tgt.green : tgt.green - ent.green;
        db = (ent.blue  > tgt.blue)  ? ent.blue  - tgt.blue  : tgt.blue  - ent.blue;
    end

    // Squares, registered
    always_ff @(posedge clk)
    begin
        sq_reg.r <= SQ_W'(dr) * SQ_W'(dr);
        sq_reg.g <= SQ_W'(dg) * SQ_W'(dg);
        sq_reg.b <= SQ_W'(db) * SQ_W'(db);
    end

    assign sq = sq_reg;

endmodule
